@@ src/cdq_pkg.sv @@
// ----------------------------------------------------------------------------
// Deque engine package
// Shared widths, command and status codes, and control bundles.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int CMD_W = 3;
   localparam int IDX_W = 5;
   localparam int VAL_W = 32;
   localparam int ST_W  = 2;
   localparam int OCC_W = 5;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_HEAD = 3'd0,
      CMD_PUSH_TAIL = 3'd1,
      CMD_INSERT    = 3'd2,
      CMD_GET       = 3'd3,
      CMD_SET       = 3'd4
   } cmd_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic ins;
      logic wr;
   } cell_op_type;

   typedef struct packed {
      status_type status;
      logic       rd;
   } rsp_info_type;

endpackage

@@ src/cdq_if.sv @@
// ----------------------------------------------------------------------------
// Deque engine channels
// Valid/ready request and response channels.
// ----------------------------------------------------------------------------
interface cdq_req_if;
   import cdq_pkg::*;

   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [IDX_W-1:0] index;
   logic [VAL_W-1:0] value;

   modport source (output valid, output command, output index, output value, input ready);
   modport sink   (input valid, input command, input index, input value, output ready);
endinterface

interface cdq_rsp_if;
   import cdq_pkg::*;

   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] read_value;
   logic [ST_W-1:0]  status;
   logic [OCC_W-1:0] occupancy_now;

   modport source (output valid, output read_value, output status, output occupancy_now,
                   input ready);
   modport sink   (input valid, input read_value, input status, input occupancy_now,
                   output ready);
endinterface

@@ src/cdq_cell.sv @@
// ----------------------------------------------------------------------------
// Deque storage cell
// Holds one entry in logical order; takes its lower neighbour's word on insert.
// ----------------------------------------------------------------------------
module cdq_cell #(
   parameter int POS        = 0,
   parameter int DEPTH      = cdq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  cdq_pkg::cell_op_type       op,
   input  logic [$clog2(DEPTH)-1:0]   sel,
   input  logic [DATA_WIDTH-1:0]      wr_data,
   input  logic [DATA_WIDTH-1:0]      prev_data,
   output logic [DATA_WIDTH-1:0]      data
);
   import cdq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] MY_POS = AW'(POS);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      priority if (op.ins && sel == MY_POS) begin
         data_in = wr_data;
      end else if (op.ins && sel < MY_POS) begin
         data_in = prev_data;
      end else if (op.wr && sel == MY_POS) begin
         data_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

@@ src/cdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Deque command control
// Decodes requests, checks fullness and range, keeps the occupancy count.
// ----------------------------------------------------------------------------
module cdq_ctrl #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic [cdq_pkg::CMD_W-1:0]   command,
   input  logic [cdq_pkg::IDX_W-1:0]   index,
   output cdq_pkg::cell_op_type        op,
   output logic [$clog2(DEPTH)-1:0]    sel,
   output cdq_pkg::rsp_info_type       info,
   output logic [cdq_pkg::OCC_W-1:0]   occ_now
);
   import cdq_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   logic [CNT_W-1:0] occ_ff;
   logic [CNT_W-1:0] occ_in;
   logic [CMP_W-1:0] idx_w;
   logic [CMP_W-1:0] occ_w;
   logic             full;
   logic             grow;
   cell_op_type      op_raw;

   assign full  = (occ_ff == CNT_W'(DEPTH));
   assign idx_w = CMP_W'(index);
   assign occ_w = CMP_W'(occ_ff);

   always_comb begin
      op_raw      = '0;
      sel         = AW'(index);
      info.status = ST_OK;
      info.rd     = 1'b0;
      grow        = 1'b0;
      unique case (cmd_type'(command))
         CMD_PUSH_HEAD: begin
            if (full) begin
               info.status = ST_FULL;
            end else begin
               op_raw.ins = 1'b1;
               sel        = '0;
               grow       = 1'b1;
            end
         end
         CMD_PUSH_TAIL: begin
            if (full) begin
               info.status = ST_FULL;
            end else begin
               op_raw.ins = 1'b1;
               sel        = AW'(occ_ff);
               grow       = 1'b1;
            end
         end
         CMD_INSERT: begin
            priority if (full) begin
               info.status = ST_FULL;
            end else if (idx_w > occ_w) begin
               info.status = ST_RANGE;
            end else begin
               op_raw.ins = 1'b1;
               grow       = 1'b1;
            end
         end
         CMD_GET: begin
            if (idx_w >= occ_w) begin
               info.status = ST_RANGE;
            end else begin
               info.rd = 1'b1;
            end
         end
         CMD_SET: begin
            if (idx_w >= occ_w) begin
               info.status = ST_RANGE;
            end else begin
               op_raw.wr = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign op      = fire ? op_raw : '0;
   assign occ_in  = (fire && grow) ? occ_ff + 1'b1 : occ_ff;
   assign occ_now = OCC_W'(occ_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(DEPTH))
      else $error("occupancy above capacity");

   a_grow: assert property (@(posedge clock) disable iff (reset)
      fire && grow |=> occ_ff == $past(occ_ff) + 1'b1)
      else $error("accepted insert did not grow the deque");

   a_reject_hold: assert property (@(posedge clock) disable iff (reset)
      fire && info.status != ST_OK |=> occ_ff == $past(occ_ff))
      else $error("rejected request changed occupancy");

   a_no_write_on_error: assert property (@(posedge clock) disable iff (reset)
      info.status != ST_OK |-> op == '0)
      else $error("cell write on rejected request");

endmodule

@@ src/circular_deque_engine_top.sv @@
// ----------------------------------------------------------------------------
// Circular deque engine
// Fixed-capacity double-ended queue held in a row of cells in logical order.
//
//   channel  | dir | fields
//   ---------+-----+--------------------------------------
//   req_chan | in  | command, index, value
//   rsp_chan | out | read_value, status, occupancy_now
//
// One request per cycle unless the response is stalled: every command,
// inserts included, completes in the cycle it is accepted, as all cells
// shift together; the response follows next cycle from the output register.
// Reset empties the deque; cell contents are not cleared.
// A stalled response holds the output register; a new request is taken in the
// same cycle that the waiting response is taken.
// ----------------------------------------------------------------------------
module circular_deque_engine_top #(
   parameter int DEPTH      = cdq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   cdq_req_if.sink      req_chan,
   cdq_rsp_if.source    rsp_chan
);
   import cdq_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic                  fire;
   cell_op_type           op;
   logic [AW-1:0]         sel;
   rsp_info_type          info;
   logic [OCC_W-1:0]      occ_now;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DATA_WIDTH-1:0] rd_word;

   logic                  rsp_valid_ff;
   logic [VAL_W-1:0]      read_value_ff;
   logic [ST_W-1:0]       status_ff;
   logic [OCC_W-1:0]      occ_out_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = req_chan.valid && req_chan.ready;
   assign wr_data        = DATA_WIDTH'(req_chan.value);

   cdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .command (req_chan.command),
      .index   (req_chan.index),
      .op      (op),
      .sel     (sel),
      .info    (info),
      .occ_now (occ_now)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         cdq_cell #(.POS(i), .DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_cell (
            .clock     (clock),
            .op        (op),
            .sel       (sel),
            .wr_data   (wr_data),
            .prev_data (wr_data),
            .data      (cell_data[i])
         );
      end else begin : g_next
         cdq_cell #(.POS(i), .DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_cell (
            .clock     (clock),
            .op        (op),
            .sel       (sel),
            .wr_data   (wr_data),
            .prev_data (cell_data[i-1]),
            .data      (cell_data[i])
         );
      end
   end

   assign rd_word = cell_data[sel];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         read_value_ff <= info.rd ? VAL_W'(rd_word) : '0;
         status_ff     <= info.status;
         occ_out_ff    <= occ_now;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.read_value    = read_value_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.occupancy_now = occ_out_ff;

endmodule
